// File: hw/rtl/sorted_array_priority_queue_macros.svh
// Assertion macros shared by the queue checker.
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define SAPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define SAPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/sapq_pkg.sv
// Types and constants of the sorted-array priority queue.
`timescale 1ns / 1ps

package sapq_pkg;

    localparam int CNT_W = 8;
    localparam logic [CNT_W-1:0] CAP_RESET = 8'd100;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    typedef struct packed {
        logic               action;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_value;
        logic [1:0]         status;
        logic [CNT_W-1:0]   entry_total;
    } out_item_t;

    // Memory read address source
    typedef enum logic [2:0] {
        RA_TOP,     // count - 1
        RA_HEAD,    // 0
        RA_SECOND,  // 1
        RA_BELOW,   // idx - 2
        RA_NEXT     // idx + 2
    } rd_src_t;

    typedef enum logic {
        WS_VAL,
        WS_RDATA
    } wr_src_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_CNT,
        IDX_ZERO,
        IDX_DEC,
        IDX_INC
    } idx_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef struct packed {
        logic       capture;
        logic       rd_en;
        rd_src_t    rd_src;
        logic       wr_en;
        wr_src_t    wr_src;
        idx_op_t    idx_op;
        cnt_op_t    cnt_op;
        logic       res_load;
        logic [1:0] res_status;
        logic       res_from_rd;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic full;      // count at or above the limit in force
        logic empty;
        logic cnt_one;
        logic idx_one;
        logic idx_last;  // idx + 2 == count
        logic gt;        // read data strictly greater than the held value
        logic out_free;
    } dp_stat_t;

endpackage

// File: hw/rtl/sapq_datapath.sv
// Datapath: sorted store, count, capacity, scan index and result registers.
`timescale 1ns / 1ps

module sapq_datapath
    import sapq_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  in_item_t        s_data,
    input  logic            cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    input  dp_cmd_t         cmd,
    output dp_stat_t        stat,
    output logic            m_valid,
    input  logic            m_ready,
    output out_item_t       m_data
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CMPW = ((AW > CNT_W) ? AW : CNT_W) + 2;

    logic [31:0]        mem [DEPTH];

    logic [CNT_W-1:0]   cap_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [AW-1:0]      idx_reg;
    logic signed [31:0] val_reg;
    logic signed [31:0] rdata_reg;
    logic signed [31:0] res_value_reg;
    logic [1:0]         res_status_reg;
    logic               m_valid_reg;
    out_item_t          m_data_reg;

    logic [AW-1:0]      rd_addr;
    logic [31:0]        wr_data;

    always_comb begin
        case (cmd.rd_src)
            RA_TOP:    rd_addr = AW'(cnt_reg - CNT_W'(1));
            RA_HEAD:   rd_addr = '0;
            RA_SECOND: rd_addr = AW'(1);
            RA_BELOW:  rd_addr = idx_reg - AW'(2);
            RA_NEXT:   rd_addr = idx_reg + AW'(2);
            default:   rd_addr = '0;
        endcase
    end

    assign wr_data = (cmd.wr_src == WS_VAL) ? val_reg : rdata_reg;

    // Store: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[idx_reg] <= wr_data;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAP_RESET;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            case (cmd.cnt_op)
                CNT_INC: cnt_reg <= cnt_reg + CNT_W'(1);
                CNT_DEC: cnt_reg <= cnt_reg - CNT_W'(1);
                default: cnt_reg <= cnt_reg;
            endcase
            case (cmd.idx_op)
                IDX_CNT:  idx_reg <= AW'(cnt_reg);
                IDX_ZERO: idx_reg <= '0;
                IDX_DEC:  idx_reg <= idx_reg - AW'(1);
                IDX_INC:  idx_reg <= idx_reg + AW'(1);
                default:  idx_reg <= idx_reg;
            endcase
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            val_reg <= s_data.value;
        end
        if (cmd.res_load) begin
            res_status_reg <= cmd.res_status;
            res_value_reg  <= cmd.res_from_rd ? rdata_reg : '0;
        end
        if (cmd.out_load) begin
            m_data_reg.out_value   <= res_value_reg;
            m_data_reg.status      <= res_status_reg;
            m_data_reg.entry_total <= cnt_reg;
        end
    end

    always_comb begin
        stat.full     = (cnt_reg >= cap_reg) || (CMPW'(cnt_reg) >= CMPW'(DEPTH));
        stat.empty    = (cnt_reg == '0);
        stat.cnt_one  = (cnt_reg == CNT_W'(1));
        stat.idx_one  = (CMPW'(idx_reg) == CMPW'(1));
        stat.idx_last = ((CMPW'(idx_reg) + CMPW'(2)) == CMPW'(cnt_reg));
        stat.gt       = (rdata_reg > val_reg);
        stat.out_free = !m_valid_reg || m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: hw/rtl/sapq_ctrl.sv
// Controller: sequences insert scans, dequeue shifts and result hand-off.
`timescale 1ns / 1ps

module sapq_ctrl
    import sapq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     s_action,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_PUT   = 6'b000100,
        S_HEAD  = 6'b001000,
        S_SHIFT = 6'b010000,
        S_RESP  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next      = state_reg;
        cmd.capture     = 1'b0;
        cmd.rd_en       = 1'b0;
        cmd.rd_src      = RA_HEAD;
        cmd.wr_en       = 1'b0;
        cmd.wr_src      = WS_VAL;
        cmd.idx_op      = IDX_HOLD;
        cmd.cnt_op      = CNT_HOLD;
        cmd.res_load    = 1'b0;
        cmd.res_status  = ST_OK;
        cmd.res_from_rd = 1'b0;
        cmd.out_load    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    if (s_action == ACT_ENQ) begin
                        if (stat.full) begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_FULL;
                            state_next     = S_RESP;
                        end else if (stat.empty) begin
                            cmd.idx_op = IDX_ZERO;
                            state_next = S_PUT;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_src = RA_TOP;
                            cmd.idx_op = IDX_CNT;
                            state_next = S_SCAN;
                        end
                    end else begin
                        if (stat.empty) begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_EMPTY;
                            state_next     = S_RESP;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_src = RA_HEAD;
                            state_next = S_HEAD;
                        end
                    end
                end
            end
            S_SCAN: begin
                // read data holds entry idx-1
                cmd.wr_en = 1'b1;
                if (stat.gt) begin
                    cmd.wr_src   = WS_VAL;
                    cmd.cnt_op   = CNT_INC;
                    cmd.res_load = 1'b1;
                    state_next   = S_RESP;
                end else begin
                    cmd.wr_src = WS_RDATA;
                    cmd.idx_op = IDX_DEC;
                    if (stat.idx_one) begin
                        state_next = S_PUT;
                    end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_src = RA_BELOW;
                    end
                end
            end
            S_PUT: begin
                cmd.wr_en    = 1'b1;
                cmd.wr_src   = WS_VAL;
                cmd.cnt_op   = CNT_INC;
                cmd.res_load = 1'b1;
                state_next   = S_RESP;
            end
            S_HEAD: begin
                cmd.res_load    = 1'b1;
                cmd.res_from_rd = 1'b1;
                if (stat.cnt_one) begin
                    cmd.cnt_op = CNT_DEC;
                    state_next = S_RESP;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_src = RA_SECOND;
                    cmd.idx_op = IDX_ZERO;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT: begin
                // read data holds entry idx+1
                cmd.wr_en  = 1'b1;
                cmd.wr_src = WS_RDATA;
                if (stat.idx_last) begin
                    cmd.cnt_op = CNT_DEC;
                    state_next = S_RESP;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_src = RA_NEXT;
                    cmd.idx_op = IDX_INC;
                end
            end
            S_RESP: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/sorted_array_priority_queue.sv
// Top level of the sorted-array priority queue.
// Usage:
//  - s_valid/s_ready/s_data: one transfer is one step, an enqueue (action 0,
//    value inserted behind all larger entries) or a dequeue (action 1, the
//    largest entry is removed). One step is worked on at a time.
//  - m_valid/m_ready/m_data: exactly one result transfer per step, in order:
//    removed value (0 unless a dequeue succeeded), status (ok, full, empty)
//    and the entry count after the step.
//  - cfg_we/cfg_wdata: capacity write, taken on any edge with cfg_we high
//    outside reset; the limit in force is the smaller of capacity and DEPTH.
// Steps from input transfer to result valid, with the output free:
//  - dropped enqueue or empty dequeue: status set at acceptance, then handed out
//  - enqueue: scan from the top, stored entries move down one per cycle, then write
//  - dequeue: head read, then one shift per cycle until the last entry moves up
// Throughput: s_ready is high only while idle, so a new step is taken only once
// the last result is loaded for output; the store moves one entry per cycle.
// Reset: count cleared, capacity set to 100, no result pending. The store
// is not cleared; only entries below the count are ever read.
// Receiver stall: the result waits in the output register; one more step is
// taken and finished, then s_ready stays low until the result is moved out.
`timescale 1ns / 1ps

module sorted_array_priority_queue
    import sapq_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer: picks the memory access and register updates each cycle
    sapq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_data.action),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Store, count, capacity and the output register
    sapq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// File: hw/rtl/sapq_checker.sv
// Port-level checker for the priority queue, bound to the top level.
`timescale 1ns / 1ps
`include "sorted_array_priority_queue_macros.svh"

module sapq_checker
    import sapq_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    `SAPQ_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")
    `SAPQ_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready, "input taken while a step is in progress")
    `SAPQ_ASSERT_NOW(a_fail_zero, m_valid && (m_data.status != ST_OK), m_data.out_value == '0, "failed step carries a value")
    `SAPQ_ASSERT_NOW(a_empty_count, m_valid && (m_data.status == ST_EMPTY), m_data.entry_total == '0, "empty status with entries stored")
    `SAPQ_ASSERT_NOW(a_count_bound, m_valid, 32'(m_data.entry_total) <= 32'(DEPTH), "entry count above depth")

endmodule

bind sorted_array_priority_queue sapq_checker #(
    .DEPTH (DEPTH)
) u_sapq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
